// ===== rtl/bph_pkg.sv =====
// ----------------------------------------------------------------------------
// bph_pkg
// Shared constants, command codes and helpers for the board position hash.
// ----------------------------------------------------------------------------
package bph_pkg;

   // defaults for the top-level parameters
   localparam int DEF_SQUARES     = 64;
   localparam int DEF_PIECE_CODES = 12;

   // piece kinds per color, castling keys after the side key
   localparam int KINDS       = 6;
   localparam int CASTLE_KEYS = 4;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 10;
   localparam int WORD_W   = 64;
   localparam int PIECE_W  = 4;
   localparam int SQ_W     = 6;
   localparam int KIND_W   = 3;
   localparam int RIGHTS_W = 4;

   // derived piece codes reach (color 2, other 3) * KINDS + 7
   localparam int CODE_W = 5;

   // key reads per item: from, to, capture, side, then castling keys
   localparam int STEPS  = 4 + CASTLE_KEYS;
   localparam int STEP_W = $clog2(STEPS);
   localparam int STEP_FROM    = 0;
   localparam int STEP_TO      = 1;
   localparam int STEP_CAPTURE = 2;
   localparam int STEP_SIDE    = 3;
   localparam int STEP_CASTLE  = 4;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_LOAD   = 3'd0;
   localparam cmd_type CMD_CLEAR  = 3'd1;
   localparam cmd_type CMD_ADD    = 3'd2;
   localparam cmd_type CMD_FINISH = 3'd3;
   localparam cmd_type CMD_MOVE   = 3'd4;

   typedef logic [WORD_W-1:0] word_type;

   // color of a piece code: 0 white, 1 black, 2 for codes past both colors
   function automatic logic [1:0] color_of(input logic [PIECE_W-1:0] code);
      logic [1:0] c;
      if (code >= PIECE_W'(2 * KINDS)) begin
         c = 2'd2;
      end else if (code >= PIECE_W'(KINDS)) begin
         c = 2'd1;
      end else begin
         c = 2'd0;
      end
      return c;
   endfunction

   // first piece code of a color
   function automatic logic [CODE_W-1:0] color_base(input logic [1:0] color);
      return CODE_W'(color) * CODE_W'(KINDS);
   endfunction

endpackage

// ===== rtl/bph_key_ram.sv =====
// ----------------------------------------------------------------------------
// bph_key_ram
// Single-port key store, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module bph_key_ram #(
   parameter int DEPTH = 773,
   parameter int AW    = 10
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic                      we,
   input  logic [AW-1:0]             addr,
   input  logic [bph_pkg::WORD_W-1:0] wdata,
   output logic [bph_pkg::WORD_W-1:0] rdata
);
   import bph_pkg::*;

   word_type mem [DEPTH];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/board_position_hash.sv =====
// ----------------------------------------------------------------------------
// board_position_hash
// Zobrist hash engine: loadable key store, accumulator, finish and move update.
// ----------------------------------------------------------------------------
//  channel | ports  | moves
//  --------+--------+---------------------------------------------------
//  input   | req_*  | one command beat with all of its operand fields
//  result  | rsp_*  | one 64-bit hash beat for every command beat
//
//  An item makes N key reads: 0 for load, clear and unused codes, up to 1 for
//  add, up to 5 for finish, up to 8 for a move update. The single-port key
//  memory gives one key per cycle, so the reads of an item follow one another.
//  Reset clears the accumulator and control; the key store is not cleared.
//  A stalled result beat sits in the output register; the next item is
//  taken meanwhile and waits at completion only if the register is full.
// ----------------------------------------------------------------------------
module board_position_hash #(
   parameter int SQUARES     = bph_pkg::DEF_SQUARES,
   parameter int PIECE_CODES = bph_pkg::DEF_PIECE_CODES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bph_pkg::CMD_W-1:0]    req_command,
   input  logic [bph_pkg::INDEX_W-1:0]  req_key_index,
   input  logic [bph_pkg::WORD_W-1:0]   req_word,
   input  logic [bph_pkg::PIECE_W-1:0]  req_piece_code,
   input  logic [bph_pkg::SQ_W-1:0]     req_from_square,
   input  logic [bph_pkg::SQ_W-1:0]     req_to_square,
   input  logic [bph_pkg::SQ_W-1:0]     req_taken_square,
   input  logic [bph_pkg::KIND_W-1:0]   req_promotion_kind,
   input  logic [bph_pkg::KIND_W-1:0]   req_captured_kind,
   input  logic                         req_black_to_move,
   input  logic [bph_pkg::RIGHTS_W-1:0] req_castling_old,
   input  logic [bph_pkg::RIGHTS_W-1:0] req_castling_new,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bph_pkg::WORD_W-1:0]   rsp_hash
);
   import bph_pkg::*;

   localparam int PIECE_SLOTS = PIECE_CODES * SQUARES;
   localparam int SIDE_SLOT   = PIECE_SLOTS;
   localparam int CASTLE_SLOT = PIECE_SLOTS + 1;
   localparam int DEPTH       = PIECE_SLOTS + 1 + CASTLE_KEYS;
   localparam int AW          = $clog2(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   function automatic logic [AW-1:0] key_addr(input logic [CODE_W-1:0] code,
                                             input logic [SQ_W-1:0]   sq);
      return AW'(int'(code) * SQUARES + int'(sq));
   endfunction

   function automatic logic key_ok(input logic [CODE_W-1:0] code,
                                   input logic [SQ_W-1:0]   sq);
      return (int'(code) < PIECE_CODES) && (int'(sq) < SQUARES);
   endfunction

   logic               state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [STEPS-1:0]   mask_ff, mask_in;
   logic               rd_pend_ff, rd_pend_in;
   word_type           work_ff, work_in;
   word_type           acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_hash_ff, rsp_hash_in;
   logic [AW-1:0]      step_addr_ff [STEPS];
   logic [AW-1:0]      step_addr_in [STEPS];

   logic               accept;
   logic               load_we;
   logic               issue;
   logic               done;
   logic [STEP_W-1:0]  sel;
   logic [STEPS-1:0]   sel_bit;
   logic [STEPS-1:0]   mask_new;
   word_type           rdata;
   word_type           fold;
   logic [AW-1:0]      ram_addr;

   // operand decode for a new beat
   logic [1:0]         color;
   logic [CODE_W-1:0]  mover, promo_code, cap_code, to_code;
   logic               mover_ok, promo, capture;
   logic [RIGHTS_W-1:0] rights;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign load_we   = accept && (req_command == CMD_LOAD) && (int'(req_key_index) < DEPTH);

   always_comb begin
      color      = color_of(req_piece_code);
      mover      = CODE_W'(req_piece_code);
      promo      = (req_promotion_kind < KIND_W'(KINDS));
      capture    = (req_captured_kind < KIND_W'(KINDS));
      promo_code = color_base(color) + CODE_W'(req_promotion_kind);
      cap_code   = color_base(color ^ 2'd1) + CODE_W'(req_captured_kind);
      to_code    = promo ? promo_code : mover;
      mover_ok   = (int'(req_piece_code) < PIECE_CODES);
      rights     = req_castling_old ^ req_castling_new;

      step_addr_in[STEP_FROM]    = key_addr(mover, req_from_square);
      step_addr_in[STEP_TO]      = key_addr(to_code, req_to_square);
      step_addr_in[STEP_CAPTURE] = key_addr(cap_code, req_taken_square);
      step_addr_in[STEP_SIDE]    = AW'(SIDE_SLOT);
      for (int i = 0; i < CASTLE_KEYS; i++) begin
         step_addr_in[STEP_CASTLE+i] = AW'(CASTLE_SLOT + i);
      end

      mask_new = '0;
      case (req_command)
         CMD_ADD: begin
            mask_new[STEP_FROM] = key_ok(mover, req_from_square);
         end
         CMD_FINISH: begin
            mask_new[STEP_SIDE] = req_black_to_move;
            mask_new[STEP_CASTLE +: CASTLE_KEYS] = req_castling_old;
         end
         CMD_MOVE: begin
            if (mover_ok) begin
               mask_new[STEP_FROM]    = key_ok(mover, req_from_square);
               mask_new[STEP_TO]      = key_ok(to_code, req_to_square);
               mask_new[STEP_CAPTURE] = capture && key_ok(cap_code, req_taken_square);
               mask_new[STEP_SIDE]    = 1'b1;
               mask_new[STEP_CASTLE +: CASTLE_KEYS] = rights;
            end
         end
         default: begin
            mask_new = '0;
         end
      endcase
   end

   // lowest pending key read
   always_comb begin
      sel = '0;
      for (int i = STEPS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = STEP_W'(i);
         end
      end
      sel_bit = STEPS'(1) << sel;
   end

   assign fold  = work_ff ^ (rd_pend_ff ? rdata : '0);
   assign issue = (state_ff == ST_RUN) && (mask_ff != '0);
   assign done  = (state_ff == ST_RUN) && (mask_ff == '0) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      mask_in     = mask_ff;
      rd_pend_in  = 1'b0;
      work_in     = fold;
      acc_in      = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in = rsp_hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               cmd_in   = req_command;
               mask_in  = mask_new;
               case (req_command)
                  CMD_MOVE:  work_in = req_word;
                  CMD_CLEAR: work_in = '0;
                  default:   work_in = acc_ff;
               endcase
            end
         end
         ST_RUN: begin
            if (issue) begin
               rd_pend_in = 1'b1;
               mask_in    = mask_ff & ~sel_bit;
            end else if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_hash_in  = fold;
               if (cmd_ff != CMD_MOVE) begin
                  acc_in = fold;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rd_pend_ff   <= rd_pend_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      work_ff     <= work_in;
      rsp_hash_ff <= rsp_hash_in;
      if (accept) begin
         for (int i = 0; i < STEPS; i++) begin
            step_addr_ff[i] <= step_addr_in[i];
         end
      end
   end

   assign ram_addr = load_we ? AW'(req_key_index) : step_addr_ff[sel];

   bph_key_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_key_ram (
      .clock (clock),
      .en    (issue || load_we),
      .we    (load_we),
      .addr  (ram_addr),
      .wdata (req_word),
      .rdata (rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

endmodule
